/* sv/assert_macros.svh */
// Assertion macros for the port checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, off while reset is asserted.
`define FNPC_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("port check failed");

// Concurrent check, active in every cycle.
`define FNPC_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("port check failed");

`endif

/* sv/fnpc_pkg.sv */
// Shared constants, types and item record of the peak clipping filter.
package fnpc_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int PIXEL_BITS    = 16;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS    = 11;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIXEL_BITS-1:0]    t_pixel;
    typedef logic [COL_BITS-1:0]      t_col;
    typedef logic [WIDTH_BITS-1:0]    t_width;
    typedef logic [FIFO_CNT_BITS-1:0] t_level;

    localparam t_width WIDTH_RESET = t_width'(MAX_WIDTH);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // One pixel to be clipped: center value and its neighbours, absent ones zero.
    typedef struct packed {
        t_pixel center;
        t_pixel up;
        t_pixel down;
        t_pixel left;
        t_pixel right;
        logic   row_end;
        logic   frame_end;
    } t_job;

    typedef struct packed {
        t_level level;
    } t_q_status;

endpackage

/* sv/four_neighbour_peak_clip.sv */
// Top level of the four-neighbour peak clipping filter.
// Throughput: one item per cycle, pixels and drain ticks alike, while full is low.
// A result is ready once the item that completes it has passed the line buffer read
// and then the queue; a pixel appears one row after it enters.
// Reset: position, row count and queue clear synchronously, width returns to 1024;
// line buffers are not cleared and are ready immediately.
module four_neighbour_peak_clip
    import fnpc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   push,
    output logic   full,
    input  logic   i_kind,
    input  t_pixel i_pixel,
    output logic   empty,
    input  logic   pop,
    output t_pixel o_value,
    output logic   o_row_end,
    output logic   o_frame_end,
    input  logic   i_cfg_we,
    input  t_width i_cfg_wdata
);

    t_q_status q_status;
    logic      job_valid;
    t_job      job;

    fnpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_kind      (i_kind),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_status  (q_status),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    fnpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_value     (o_value),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end),
        .o_q_status  (q_status)
    );

endmodule

/* sv/fnpc_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle.
module fnpc_ram #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_BITS-1:0]     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_BITS-1:0]     o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fnpc_front.sv */
// Front end: accepts items, tracks raster position, line buffers, gathers neighbours.
module fnpc_front
    import fnpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  logic      i_kind,
    input  t_pixel    i_pixel,
    input  logic      i_cfg_we,
    input  t_width    i_cfg_wdata,
    input  t_q_status i_q_status,
    output logic      o_job_valid,
    output t_job      o_job
);

    function automatic t_width clamp_width(input t_width w);
        if (w == '0) begin
            return t_width'(1);
        end else if (int'(w) > MAX_WIDTH) begin
            return t_width'(MAX_WIDTH);
        end
        return w;
    endfunction

    t_width     r_width, n_width;
    t_col       r_col, n_col;
    logic [1:0] r_rows, n_rows;
    t_col       r_drain, n_drain;
    logic       r_byp;
    t_pixel     r_byp_data;
    t_pixel     r_prev;

    logic       r_s1_valid;
    t_pixel     r_s1_center;
    t_pixel     r_s1_down;
    t_pixel     r_s1_left;
    logic       r_s1_has_up;
    logic       r_s1_has_right;
    logic       r_s1_row_end;
    logic       r_s1_frame_end;

    t_width     w_eff, n_w_eff;
    logic       accept;
    t_col       c;
    t_col       col_eff;
    logic [1:0] rows_eff;
    logic       emit, last, has_up, frame_end, wr_pd, wr_ra, is_pixel;
    t_pixel     cur;
    t_pixel     pd_rdata, ra_rdata;
    t_col       pd_raddr;

    assign w_eff  = clamp_width(r_width);
    assign o_full = (int'(i_q_status.level) + int'(r_s1_valid)) >= FIFO_DEPTH;
    assign accept = i_push && !o_full;
    assign cur    = r_byp ? r_byp_data : pd_rdata;

    always_comb begin
        n_width   = i_cfg_we ? i_cfg_wdata : r_width;
        n_col     = r_col;
        n_rows    = r_rows;
        n_drain   = r_drain;
        c         = '0;
        col_eff   = '0;
        rows_eff  = '0;
        emit      = 1'b0;
        last      = 1'b0;
        has_up    = 1'b0;
        frame_end = 1'b0;
        wr_pd     = 1'b0;
        wr_ra     = 1'b0;
        is_pixel  = 1'b0;
        if (accept) begin
            if (i_kind == KIND_PIXEL) begin
                is_pixel = 1'b1;
                rows_eff = (r_drain != '0) ? 2'd0 : r_rows;
                col_eff  = (r_drain != '0) ? t_col'(0) : r_col;
                if (t_width'(col_eff) >= w_eff) begin
                    col_eff = '0;
                end
                c       = col_eff;
                last    = (t_width'(c) + t_width'(1)) == w_eff;
                emit    = rows_eff != 2'd0;
                has_up  = rows_eff >= 2'd2;
                wr_pd   = 1'b1;
                wr_ra   = emit;
                n_drain = '0;
                if (last) begin
                    n_col  = '0;
                    n_rows = (rows_eff >= 2'd2) ? 2'd2 : rows_eff + 2'd1;
                end else begin
                    n_col  = c + t_col'(1);
                    n_rows = rows_eff;
                end
            end else if (r_rows != 2'd0 && r_col == '0) begin
                c = r_drain;
                if (t_width'(c) >= w_eff) begin
                    n_rows  = 2'd0;
                    n_drain = '0;
                end else begin
                    emit      = 1'b1;
                    last      = (t_width'(c) + t_width'(1)) == w_eff;
                    has_up    = r_rows >= 2'd2;
                    frame_end = last;
                    if (last) begin
                        n_rows  = 2'd0;
                        n_drain = '0;
                    end else begin
                        n_drain = c + t_col'(1);
                    end
                end
            end
        end
    end

    // Prefetch the center of the next item; it is also the right neighbour of this one.
    assign n_w_eff  = clamp_width(n_width);
    assign pd_raddr = (n_drain != '0) ? n_drain :
                      ((t_width'(n_col) >= n_w_eff) ? t_col'(0) : n_col);

    fnpc_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PIXEL_BITS)
    ) u_pending (
        .i_clk   (i_clk),
        .i_we    (wr_pd),
        .i_waddr (c),
        .i_wdata (i_pixel),
        .i_raddr (pd_raddr),
        .o_rdata (pd_rdata)
    );

    fnpc_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PIXEL_BITS)
    ) u_row_above (
        .i_clk   (i_clk),
        .i_we    (wr_ra),
        .i_waddr (c),
        .i_wdata (cur),
        .i_raddr (c),
        .o_rdata (ra_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RESET;
            r_col      <= '0;
            r_rows     <= 2'd0;
            r_drain    <= '0;
            r_byp      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_width    <= n_width;
            r_col      <= n_col;
            r_rows     <= n_rows;
            r_drain    <= n_drain;
            r_byp      <= wr_pd && (pd_raddr == c);
            r_s1_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_pixel;
        if (is_pixel || emit) begin
            r_prev <= cur;
        end
        if (emit) begin
            r_s1_center    <= cur;
            r_s1_down      <= is_pixel ? i_pixel : t_pixel'(0);
            r_s1_left      <= (c != '0) ? r_prev : t_pixel'(0);
            r_s1_has_up    <= has_up;
            r_s1_has_right <= !last;
            r_s1_row_end   <= last;
            r_s1_frame_end <= frame_end;
        end
    end

    assign o_job_valid     = r_s1_valid;
    assign o_job.center    = r_s1_center;
    assign o_job.up        = r_s1_has_up ? ra_rdata : t_pixel'(0);
    assign o_job.down      = r_s1_down;
    assign o_job.left      = r_s1_left;
    assign o_job.right     = r_s1_has_right ? pd_rdata : t_pixel'(0);
    assign o_job.row_end   = r_s1_row_end;
    assign o_job.frame_end = r_s1_frame_end;

endmodule

/* sv/fnpc_back.sv */
// Back end: item queue and the peak clip applied to the oldest item.
module fnpc_back
    import fnpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    input  logic      i_pop,
    output logic      o_empty,
    output t_pixel    o_value,
    output logic      o_row_end,
    output logic      o_frame_end,
    output t_q_status o_q_status
);

    t_job                     r_q [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wp, r_rp;
    t_level                   r_level;

    logic   pop;
    t_job   head;
    t_pixel max_ud, max_lr, max_all;
    logic   peak;

    assign o_empty = r_level == '0;
    assign pop     = i_pop && !o_empty;
    assign head    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_job_valid) begin
                r_wp <= (r_wp == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_level <= r_level + t_level'(i_job_valid) - t_level'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_q[r_wp] <= i_job;
        end
    end

    assign max_ud  = (head.up > head.down) ? head.up : head.down;
    assign max_lr  = (head.left > head.right) ? head.left : head.right;
    assign max_all = (max_ud > max_lr) ? max_ud : max_lr;
    assign peak    = (head.up < head.center) && (head.down < head.center) &&
                     (head.left < head.center) && (head.right < head.center);

    assign o_value          = peak ? max_all : head.center;
    assign o_row_end        = head.row_end;
    assign o_frame_end      = head.frame_end;
    assign o_q_status.level = r_level;

endmodule

/* sv/fnpc_port_check.sv */
// Port-level checker for the peak clipping filter, bound to the top level.
`include "assert_macros.svh"

module fnpc_port_check
    import fnpc_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   push,
    input logic   full,
    input logic   empty,
    input logic   pop,
    input t_pixel o_value,
    input logic   o_row_end,
    input logic   o_frame_end
);

    logic accept;

    assign accept = push && !full;

    `FNPC_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> empty)
    `FNPC_ASSERT_RST(a_frame_end_row_end, i_clk, i_rst_n, !empty && o_frame_end |-> o_row_end)
    `FNPC_ASSERT_RST(a_full_has_items, i_clk, i_rst_n, full |-> !empty)
    `FNPC_ASSERT_RST(a_no_spurious_item, i_clk, i_rst_n, empty && !accept && $past(!accept) |=> empty)
    `FNPC_ASSERT_RST(a_head_holds, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_value))

endmodule

bind four_neighbour_peak_clip fnpc_port_check u_port_check (.*);

/* tb/sv/tb_four_neighbour_peak_clip.sv */
// Self-checking testbench for the four-neighbour peak clipping filter.
module tb_four_neighbour_peak_clip;
    timeunit 1ns;
    timeprecision 1ps;
    import fnpc_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TOTAL_ITEMS   = 1150;
    localparam int WIDE_FLUSH    = 24;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        t_pixel value;
        logic   row_end;
        logic   frame_end;
    } t_clipped_px;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   push;
    logic   full;
    logic   i_kind;
    t_pixel i_pixel;
    logic   empty;
    logic   pop;
    t_pixel o_value;
    logic   o_row_end;
    logic   o_frame_end;
    logic   i_cfg_we;
    t_width i_cfg_wdata;

    t_pixel     line_above [MAX_WIDTH];
    t_pixel     line_held [MAX_WIDTH];
    t_pixel     left_px;
    t_col       col_pos;
    logic [1:0] rows_done;
    t_width     flush_pos;
    t_width     width_reg;

    t_clipped_px due_pixels[$];
    int          mismatches;
    int          results_seen;
    int          items_counted;
    int          peaks_clipped;
    int          frames_run;
    int          cycles;
    bit          send_quiet;
    bit          recv_quiet;

    four_neighbour_peak_clip dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_value     (o_value),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic bit at_frame_start();
        return rows_done == 0 && col_pos == 0 && flush_pos == 0;
    endfunction

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic t_pixel clip_value(input int c, input int w, input bit has_down,
                                          input t_pixel down);
        t_pixel nb [4];
        t_pixel v;
        t_pixel mx;
        int     n;
        bit     peak;
        n = 0;
        v = line_held[c];
        mx = '0;
        peak = 1'b1;
        if (rows_done >= 2) begin
            nb[n] = line_above[c];
            n++;
        end
        if (has_down) begin
            nb[n] = down;
            n++;
        end
        if (c > 0) begin
            nb[n] = left_px;
            n++;
        end
        if (c + 1 < w) begin
            nb[n] = line_held[c + 1];
            n++;
        end
        for (int i = 0; i < n; i++) begin
            if (nb[i] >= v) peak = 1'b0;
            if (nb[i] > mx) mx = nb[i];
        end
        if (peak) peaks_clipped++;
        return peak ? mx : v;
    endfunction

    task automatic end_flush();
        rows_done = '0;
        flush_pos = '0;
        left_px = '0;
    endtask

    task automatic model_item(input logic kind, input t_pixel px);
        int          w;
        int          c;
        t_clipped_px r;
        w = eff_width();
        if (kind == KIND_PIXEL) begin
            if (flush_pos != 0) begin
                end_flush();
                col_pos = '0;
            end
            if (int'(col_pos) >= w) col_pos = '0;
            c = int'(col_pos);
            if (rows_done >= 1) begin
                r.value = clip_value(c, w, 1'b1, px);
                r.row_end = (c + 1 == w);
                r.frame_end = 1'b0;
                due_pixels = {due_pixels, r};
                line_above[c] = line_held[c];
            end
            left_px = line_held[c];
            line_held[c] = px;
            if (c + 1 >= w) begin
                col_pos = '0;
                left_px = '0;
                if (rows_done < 2) rows_done++;
            end else begin
                col_pos = t_col'(c + 1);
            end
        end else if (rows_done != 0 && col_pos == 0) begin
            c = int'(flush_pos);
            if (c >= w) begin
                end_flush();
            end else begin
                r.value = clip_value(c, w, 1'b0, '0);
                r.row_end = (c + 1 == w);
                r.frame_end = r.row_end;
                due_pixels = {due_pixels, r};
                left_px = line_held[c];
                if (c + 1 >= w) end_flush();
                else flush_pos = t_width'(c + 1);
            end
        end
    endtask

    task automatic send_item(input logic kind, input t_pixel px);
        int gap;
        gap = draw_gap(send_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_kind <= kind;
        i_pixel <= px;
        do @(posedge i_clk); while (full !== 1'b0);
        if (kind == KIND_PIXEL || (rows_done != 0 && col_pos == 0)) items_counted++;
        model_item(kind, px);
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        push <= 1'b0;
        while (due_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input t_width value);
        settle_block();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        width_reg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic shrink_width();
        if (eff_width() > 1) write_width(t_width'($urandom_range(0, eff_width() - 1)));
    endtask

    function automatic t_pixel next_pixel(input int style);
        case (style)
            0: return t_pixel'($urandom);
            1: return t_pixel'($urandom_range(0, 3));
            default: return 16'hFFFF - t_pixel'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic t_width pick_width();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return t_width'(1);
        if (r <= 12) return t_width'($urandom_range(2, 8));
        return t_width'($urandom_range(9, 40));
    endfunction

    task automatic test_widest_frame();
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        for (int i = 0; i < MAX_WIDTH; i++) send_item(KIND_PIXEL, t_pixel'($urandom));
        write_width(t_width'(2047));
        repeat (WIDE_FLUSH) send_item(KIND_DRAIN, t_pixel'($urandom));
    endtask

    task automatic test_lone_pixel();
        write_width('0);
        send_item(KIND_PIXEL, 16'hFFFF);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_DRAIN, 16'hFFFF);
        send_item(KIND_PIXEL, 16'h8000);
        send_item(KIND_PIXEL, 16'h7FFF);
        send_item(KIND_DRAIN, '0);
    endtask

    task automatic test_peaks_and_edges();
        write_width(t_width'(3));
        send_item(KIND_PIXEL, 16'h0000);
        send_item(KIND_PIXEL, 16'hFFFF);
        send_item(KIND_PIXEL, 16'h8000);
        send_item(KIND_PIXEL, 16'hFFFF);
        send_item(KIND_PIXEL, 16'h0001);
        send_item(KIND_PIXEL, 16'hFFFF);
        send_item(KIND_PIXEL, 16'h1234);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_PIXEL, 16'h1234);
        send_item(KIND_PIXEL, 16'hFFFF);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_DRAIN, '0);
        send_item(KIND_PIXEL, 16'hFFFF);
        send_item(KIND_PIXEL, 16'h0000);
        send_item(KIND_PIXEL, 16'h0001);
        repeat (3) send_item(KIND_DRAIN, '0);
    endtask

    task automatic test_random_frames();
        int rows;
        int target;
        int sent;
        int shrink_at;
        int cut;
        int k;
        int style;
        while (items_counted < TOTAL_ITEMS) begin
            send_quiet = ($urandom_range(0, 2) == 0);
            recv_quiet = ($urandom_range(0, 2) == 0);
            style = $urandom_range(0, 2);
            if (at_frame_start() && $urandom_range(0, 2) != 0) write_width(pick_width());
            rows = $urandom_range(1, 5);
            target = rows * eff_width();
            shrink_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, target - 1) : -1;
            sent = 0;
            while (sent < target || col_pos != 0) begin
                if (sent == shrink_at) shrink_width();
                if (col_pos != 0 && $urandom_range(0, 19) == 0)
                    send_item(KIND_DRAIN, t_pixel'($urandom));
                send_item(KIND_PIXEL, next_pixel(style));
                sent++;
            end
            cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, eff_width() - 1) : -1;
            shrink_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff_width() - 1) : -1;
            k = 0;
            while (rows_done != 0 && k != cut) begin
                if (k == shrink_at) shrink_width();
                send_item(KIND_DRAIN, t_pixel'($urandom));
                k++;
            end
            if ($urandom_range(0, 4) == 0) send_item(KIND_DRAIN, t_pixel'($urandom));
            frames_run++;
        end
    endtask

    initial begin : result_receiver
        int stall;
        pop = 1'b0;
        forever begin
            stall = draw_gap(recv_quiet);
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && empty === 1'b0));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_clipped_px want;
        if (i_rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
            results_seen++;
            if (due_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result: value %h row_end %b frame_end %b",
                             o_value, o_row_end, o_frame_end);
            end else begin
                want = due_pixels.pop_front();
                if (o_value !== want.value || o_row_end !== want.row_end ||
                    o_frame_end !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Mismatch at result %0d: expected %h/%b/%b, got %h/%b/%b",
                                 results_seen, want.value, want.row_end, want.frame_end,
                                 o_value, o_row_end, o_frame_end);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_kind = KIND_PIXEL;
        i_pixel = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        width_reg = WIDTH_RESET;
        left_px = '0;
        col_pos = '0;
        rows_done = '0;
        flush_pos = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_widest_frame();
        test_lone_pixel();
        test_peaks_and_edges();
        test_random_frames();

        settle_block();
        repeat (20) @(posedge i_clk);
        if (due_pixels.size() != 0) begin
            $display("%0d expected results never arrived", due_pixels.size());
            mismatches += due_pixels.size();
        end
        $display("Covered %0d items: a 1024-pixel row, directed edge cases, %0d random frames.",
                 items_counted, frames_run);
        $display("Checked %0d results, %0d of them clipped peaks.", results_seen, peaks_clipped);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/fnpc_pkg.sv
sv/fnpc_ram.sv
sv/fnpc_front.sv
sv/fnpc_back.sv
sv/four_neighbour_peak_clip.sv
sv/fnpc_port_check.sv
tb/sv/tb_four_neighbour_peak_clip.sv
